// ----- rtl/core/icsum_pkg.sv -----
// Shared types, register map and ones' complement helpers for the checksum block.
package icsum_pkg;

  // Configuration port geometry
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegSrcAddr  = 2'd0;
  localparam logic [1:0] RegDstAddr  = 2'd1;
  localparam logic [1:0] RegProtocol = 2'd2;
  localparam logic [1:0] RegMode     = 2'd3;

  // checksum_mode codes
  localparam logic ModePseudo  = 1'b0;
  localparam logic ModePayload = 1'b1;

  // Register contents handed from the config port to the datapath
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic        mode;
  } cfg_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Fold a sum of up to eight 16-bit words back to 16 bits (zero stays zero)
  function automatic logic [15:0] fold19(input logic [18:0] w);
    logic [16:0] f;
    f = {1'b0, w[15:0]} + {14'd0, w[18:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

// ----- rtl/core/icsum_apb.sv -----
// APB register file holding the pseudo-header fields and the checksum mode.
module icsum_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icsum_pkg::AddrW-1:0]   paddr,
  input  logic [icsum_pkg::DataW-1:0]   pwdata,
  output logic [icsum_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output icsum_pkg::cfg_t               cfg_o
);

  icsum_pkg::cfg_t cfg_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        icsum_pkg::RegSrcAddr:  cfg_q.src_addr <= pwdata;
        icsum_pkg::RegDstAddr:  cfg_q.dst_addr <= pwdata;
        icsum_pkg::RegProtocol: cfg_q.protocol <= pwdata[7:0];
        icsum_pkg::RegMode:     cfg_q.mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      icsum_pkg::RegSrcAddr:  prdata = cfg_q.src_addr;
      icsum_pkg::RegDstAddr:  prdata = cfg_q.dst_addr;
      icsum_pkg::RegProtocol: prdata = {24'd0, cfg_q.protocol};
      icsum_pkg::RegMode:     prdata = {31'd0, cfg_q.mode};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/icsum_core.sv -----
// Byte datapath: input register, running ones' complement sum, result register.
module icsum_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  icsum_pkg::cfg_t cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     out_csum_o
);

  // Input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;

  // Per-packet state
  logic [15:0] run_sum_q, run_sum_d;
  logic [7:0]  held_q, held_d;
  logic        odd_q, odd_d;
  logic [15:0] count_q, count_d;

  // Result register
  logic        out_valid_q;
  logic [15:0] out_csum_q;

  logic        out_free;
  logic        s1_move;
  logic [15:0] word;
  logic [15:0] count_inc;
  logic [18:0] wide_sum;
  logic        use_pseudo;
  logic [15:0] final_sum;

  assign out_free   = !out_valid_q || out_ready_i;
  // A non-last beat never needs the result slot
  assign s1_move    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_move;

  // Word completed by this beat: pair with the held byte, else pad low byte
  assign word      = odd_q ? {held_q, s1_byte_q} : {s1_byte_q, 8'h00};
  assign count_inc = count_q + 16'd1;

  // Final sum: all words folded once
  assign use_pseudo = (cfg_i.mode == icsum_pkg::ModePseudo);
  always_comb begin
    wide_sum = {3'd0, run_sum_q} + {3'd0, word};
    if (use_pseudo) begin
      wide_sum = wide_sum
               + {3'd0, cfg_i.src_addr[31:16]} + {3'd0, cfg_i.src_addr[15:0]}
               + {3'd0, cfg_i.dst_addr[31:16]} + {3'd0, cfg_i.dst_addr[15:0]}
               + {11'd0, cfg_i.protocol} + {3'd0, count_inc};
    end
    final_sum = icsum_pkg::fold19(wide_sum);
  end

  // Next packet state
  always_comb begin
    run_sum_d = run_sum_q;
    held_d    = held_q;
    odd_d     = odd_q;
    count_d   = count_q;
    if (s1_move) begin
      if (s1_last_q) begin
        run_sum_d = '0;
        held_d    = '0;
        odd_d     = 1'b0;
        count_d   = '0;
      end else begin
        count_d = count_inc;
        if (odd_q) begin
          run_sum_d = icsum_pkg::ones_add(run_sum_q, word);
          held_d    = '0;
          odd_d     = 1'b0;
        end else begin
          held_d = s1_byte_q;
          odd_d  = 1'b1;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
  end

  // Packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q <= '0;
      held_q    <= '0;
      odd_q     <= 1'b0;
      count_q   <= '0;
    end else begin
      run_sum_q <= run_sum_d;
      held_q    <= held_d;
      odd_q     <= odd_d;
      count_q   <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_last_q) begin
      out_csum_q <= ~final_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_csum_o  = out_csum_q;

endmodule

// ----- rtl/core/internet_checksum_pseudo_header.sv -----
// Internet checksum with optional IPv4 pseudo-header, one byte per clock.
// The checksum beat is registered in the result register after the last byte has passed the input register.
// Throughput: one byte per cycle; the running 16-bit end-around-carry add sets the rate.
// Output back-pressure stalls input only when a last byte reaches the full result register.
// Reset (rst_ni, async low) clears the config registers, the running sum, byte count and pipeline valids.
module internet_checksum_pseudo_header (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Byte stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // last_byte
  // Checksum out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // [15:0] checksum
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icsum_pkg::AddrW-1:0]  paddr,
  input  logic [icsum_pkg::DataW-1:0]  pwdata,
  output logic [icsum_pkg::DataW-1:0]  prdata,
  output logic                         pready
);

  icsum_pkg::cfg_t cfg;

  icsum_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  icsum_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_csum_o  (m_axis_tdata)
  );

endmodule
